>>> src/lcd_pkg.sv
`default_nettype none

package lcd_pkg;

    localparam int VALUE_W        = 32;
    localparam int DEC_DIGITS     = 10;               // decimal digits of a 32-bit value
    localparam int BCD_W          = 4 * DEC_DIGITS;
    localparam int STEP_BITS      = 8;                // shift-add-3 steps per stage
    localparam int DD_STAGES      = VALUE_W / STEP_BITS;
    localparam int PAYLOAD_DEF    = 8;
    localparam int SUM_W          = 7;                // 9 digits of at most 9
    localparam int TDATA_IN_W     = 32;
    localparam int TUSER_IN_W     = 2;
    localparam int TDATA_OUT_W    = 32;
    localparam int TUSER_OUT_W    = 1;

    // reciprocal of ten, exact for every 32-bit dividend with a shift of 35
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_VERIFY = 2'd1;
    localparam logic [1:0] MODE_STRIP  = 2'd2;

    localparam logic [VALUE_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic [VALUE_W-1:0] bin;    // bits still to shift in, MSB first
        logic [BCD_W-1:0]   bcd;
    } t_dd_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
        logic               last;
    } t_result;

    // doubled digit with its two decimal digits summed
    function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
        logic [4:0] twice;
        twice = {d, 1'b0};
        if (d < 4'd5) begin
            luhn_dbl = twice[3:0];
        end else begin
            luhn_dbl = 4'(twice - 5'd9);
        end
    endfunction

endpackage

`default_nettype wire

>>> src/lcd_bcd_stage.sv
`default_nettype none

// Eight shift-add-3 steps of the binary to BCD conversion, registered.
module lcd_bcd_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire lcd_pkg::t_dd_item i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output lcd_pkg::t_dd_item      o_item
);

    logic              r_valid;
    lcd_pkg::t_dd_item r_item;
    lcd_pkg::t_dd_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item = i_item;
        for (int s = 0; s < lcd_pkg::STEP_BITS; s++) begin
            for (int k = 0; k < lcd_pkg::DEC_DIGITS; k++) begin
                if (n_item.bcd[k*4 +: 4] >= 4'd5) begin
                    n_item.bcd[k*4 +: 4] = n_item.bcd[k*4 +: 4] + 4'd3;
                end
            end
            n_item.bcd = {n_item.bcd[lcd_pkg::BCD_W-2:0], n_item.bin[lcd_pkg::VALUE_W-1]};
            n_item.bin = {n_item.bin[lcd_pkg::VALUE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

>>> src/lcd_luhn_eval.sv
`default_nettype none

// Two stages: weighted digit sum, range flags and strip quotient; then the
// check digit and the mode decision into the output register.
module lcd_luhn_eval #(
    parameter int PAYLOAD_DIGITS = lcd_pkg::PAYLOAD_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire lcd_pkg::t_dd_item i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output lcd_pkg::t_result       o_result
);

    localparam int VW = lcd_pkg::VALUE_W;

    // stage A
    logic                     r_a_valid;
    logic [1:0]               r_a_mode;
    logic [VW-1:0]            r_a_value;
    logic                     r_a_last;
    logic [lcd_pkg::SUM_W-1:0] r_a_sum;
    logic [3:0]               r_a_chk_in;
    logic                     r_a_add_big;
    logic                     r_a_ver_big;
    logic [VW-1:0]            r_a_quot;

    logic [lcd_pkg::SUM_W-1:0] n_a_sum;
    logic                     n_a_add_big;
    logic                     n_a_ver_big;
    logic [2*VW-1:0]          a_prod;
    logic [3:0]               a_dg;

    // stage B
    logic                     r_b_valid;
    lcd_pkg::t_result         r_b_result;
    lcd_pkg::t_result         n_b_result;
    logic                     a_ready;
    logic                     b_ready;

    logic [14:0]              b_q_prod;
    logic [3:0]               b_q;
    logic [6:0]               b_rem;
    logic [3:0]               b_chk;
    logic [VW+3:0]            b_add_wide;
    logic                     b_match;

    assign b_ready  = !r_b_valid || i_ready;
    assign a_ready  = !r_a_valid || b_ready;
    assign o_ready  = a_ready;
    assign o_valid  = r_b_valid;
    assign o_result = r_b_result;

    always_comb begin
        n_a_sum     = '0;
        n_a_add_big = 1'b0;
        n_a_ver_big = 1'b0;
        a_dg        = '0;
        for (int i = 0; i < PAYLOAD_DIGITS; i++) begin
            // add works on the value itself, verify and strip on value / 10
            if (i_item.mode == lcd_pkg::MODE_ADD) begin
                a_dg = i_item.bcd[i*4 +: 4];
            end else begin
                a_dg = i_item.bcd[(i+1)*4 +: 4];
            end
            if ((i % 2) == 0) begin
                a_dg = lcd_pkg::luhn_dbl(a_dg);
            end
            n_a_sum = n_a_sum + lcd_pkg::SUM_W'(a_dg);
        end
        for (int k = 0; k < lcd_pkg::DEC_DIGITS; k++) begin
            if (k >= PAYLOAD_DIGITS && i_item.bcd[k*4 +: 4] != 4'd0) begin
                n_a_add_big = 1'b1;
            end
            if (k >= PAYLOAD_DIGITS + 1 && i_item.bcd[k*4 +: 4] != 4'd0) begin
                n_a_ver_big = 1'b1;
            end
        end
    end

    assign a_prod = (2*VW)'(i_item.value) * (2*VW)'(lcd_pkg::RECIP10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_mode    <= i_item.mode;
            r_a_value   <= i_item.value;
            r_a_last    <= i_item.last;
            r_a_sum     <= n_a_sum;
            r_a_chk_in  <= i_item.bcd[3:0];
            r_a_add_big <= n_a_add_big;
            r_a_ver_big <= n_a_ver_big;
            r_a_quot    <= VW'(a_prod >> lcd_pkg::RECIP10_SHIFT);
        end
    end

    // sum mod 10 by reciprocal: exact for sums up to 81
    assign b_q_prod   = 15'(r_a_sum) * 15'd205;
    assign b_q        = b_q_prod[14:11];
    assign b_rem      = r_a_sum - 7'(b_q) * 7'd10;
    assign b_chk      = (b_rem == 7'd0) ? 4'd0 : 4'(7'd10 - b_rem);
    assign b_add_wide = {1'b0, r_a_value, 3'b000} + {3'b000, r_a_value, 1'b0}
                        + (VW+4)'(b_chk);
    assign b_match    = !r_a_ver_big && (b_chk == r_a_chk_in);

    always_comb begin
        n_b_result.value = lcd_pkg::ALL_ONES;
        n_b_result.ok    = 1'b0;
        n_b_result.last  = r_a_last;
        case (r_a_mode)
            lcd_pkg::MODE_ADD: begin
                if (!r_a_add_big && b_add_wide[VW+3:VW] == 4'd0) begin
                    n_b_result.value = b_add_wide[VW-1:0];
                    n_b_result.ok    = 1'b1;
                end
            end
            lcd_pkg::MODE_VERIFY: begin
                n_b_result.value = '0;
                n_b_result.ok    = b_match;
            end
            lcd_pkg::MODE_STRIP: begin
                n_b_result.ok = b_match;
                if (b_match) begin
                    n_b_result.value = r_a_quot;
                end
            end
            default: begin
                n_b_result.value = lcd_pkg::ALL_ONES;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_result <= n_b_result;
        end
    end

endmodule

`default_nettype wire

>>> src/luhn_check_digit_unit.sv
// Luhn mod-10 check digit unit. Each transfer carries a 32-bit value in
// tdata and a mode in tuser: add (0) appends the check digit of the
// PAYLOAD_DIGITS-digit payload, verify (1) checks a value whose last decimal
// digit is the check digit and returns result 0, strip (2) checks and returns
// the payload (value / 10). Errors (payload too large, mismatch, mode 3) give
// all ones with check_ok low; a failed verify gives 0. tlast passes through.
// One transfer is taken every clock cycle unless backpressure has filled the
// pipeline; each result passes through four binary-to-BCD stages of eight
// shift-add-3 steps each, one stage for the weighted digit sum, range test and
// strip quotient multiply, and the output register. Backpressure stalls the
// pipeline stage by stage; empty stages keep filling while the output is held.
`default_nettype none

module luhn_check_digit_unit #(
    parameter int PAYLOAD_DIGITS = lcd_pkg::PAYLOAD_DEF   // 1 to 9
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [lcd_pkg::TDATA_IN_W-1:0]  s_axis_tdata,   // [31:0] value
    input  wire logic [lcd_pkg::TUSER_IN_W-1:0]  s_axis_tuser,   // [1:0] mode
    input  wire logic                            s_axis_tlast,   // batch_end
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [lcd_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,   // [31:0] result_value
    output logic [lcd_pkg::TUSER_OUT_W-1:0]      m_axis_tuser,   // [0] check_ok
    output logic                                 m_axis_tlast    // batch_last
);

    localparam int NS = lcd_pkg::DD_STAGES;

    // conversion chain: slot 0 is the input, slot NS feeds the evaluator
    logic              dd_valid [NS+1];
    logic              dd_ready [NS+1];
    lcd_pkg::t_dd_item dd_item  [NS+1];
    lcd_pkg::t_result  result;

    // start the conversion with an empty BCD field
    assign dd_valid[0]      = s_axis_tvalid;
    assign s_axis_tready    = dd_ready[0];
    assign dd_item[0].mode  = s_axis_tuser;
    assign dd_item[0].value = s_axis_tdata;
    assign dd_item[0].last  = s_axis_tlast;
    assign dd_item[0].bin   = s_axis_tdata;
    assign dd_item[0].bcd   = '0;

    for (genvar g = 0; g < NS; g++) begin : g_bcd
        lcd_bcd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dd_valid[g]),
            .o_ready (dd_ready[g]),
            .i_item  (dd_item[g]),
            .o_valid (dd_valid[g+1]),
            .i_ready (dd_ready[g+1]),
            .o_item  (dd_item[g+1])
        );
    end

    lcd_luhn_eval #(
        .PAYLOAD_DIGITS (PAYLOAD_DIGITS)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dd_valid[NS]),
        .o_ready  (dd_ready[NS]),
        .i_item   (dd_item[NS]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = result.value;
    assign m_axis_tuser = result.ok;
    assign m_axis_tlast = result.last;

endmodule

`default_nettype wire

>>> src/lcd_checker.sv
`default_nettype none

module lcd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // a failed check returns zero (verify) or all ones
    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata == 32'h0 || m_axis_tdata == 32'hFFFF_FFFF)
        else $error("failed check with a payload value");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // input backpressure only when the output itself is stalled
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with free output");

endmodule

bind luhn_check_digit_unit lcd_checker u_lcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> sim/luhn_check_digit_unit_test.sv
`default_nettype none

module luhn_check_digit_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD     = 12;
    localparam int          PAYLOAD_DIGITS = 8;
    localparam logic [63:0] PAYLOAD_MAX    = 64'd99_999_999;
    localparam logic [63:0] FULL_MAX       = 64'd999_999_999;
    localparam logic [1:0]  MODE_UNUSED    = 2'd3;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          ITEMS_PER_SEG  = 190;
    localparam int          NUM_SEGMENTS   = 6;

    // one row of the directed table; typed rows carry their own answer
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        logic        last;
        logic        typed;
        logic [31:0] exp_value;
        logic        exp_ok;
    } t_stim_row;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
        logic        last;
    } t_luhn_result;

    localparam int NUM_DIRECTED = 22;
    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        // add: zero, payload limit, just over it, far over it, and other payloads
        '{lcd_pkg::MODE_ADD,    32'd0,          1'b0, TYPED,     32'd0,    1'b1},
        '{lcd_pkg::MODE_ADD,    32'd99999999,   1'b0, PREDICTED, 32'd0,    1'b0},
        '{lcd_pkg::MODE_ADD,    32'd100000000,  1'b0, TYPED, lcd_pkg::ALL_ONES, 1'b0},
        '{lcd_pkg::MODE_ADD,    32'hFFFF_FFFF,  1'b1, TYPED, lcd_pkg::ALL_ONES, 1'b0},
        '{lcd_pkg::MODE_ADD,    32'd1,          1'b0, PREDICTED, 32'd0,    1'b0},
        '{lcd_pkg::MODE_ADD,    32'd79927398,   1'b0, PREDICTED, 32'd0,    1'b0},
        '{lcd_pkg::MODE_ADD,    32'h7FFF_FFFF,  1'b0, TYPED, lcd_pkg::ALL_ONES, 1'b0},
        // verify: result field is always zero
        '{lcd_pkg::MODE_VERIFY, 32'd0,          1'b0, TYPED,     32'd0,    1'b1},
        '{lcd_pkg::MODE_VERIFY, 32'd799273985,  1'b0, PREDICTED, 32'd0,    1'b0},
        '{lcd_pkg::MODE_VERIFY, 32'd999999999,  1'b0, PREDICTED, 32'd0,    1'b0},
        '{lcd_pkg::MODE_VERIFY, 32'd999999998,  1'b1, PREDICTED, 32'd0,    1'b0},
        '{lcd_pkg::MODE_VERIFY, 32'd1000000000, 1'b0, TYPED,     32'd0,    1'b0},
        '{lcd_pkg::MODE_VERIFY, 32'hFFFF_FFFF,  1'b0, TYPED,     32'd0,    1'b0},
        // strip: match, mismatch, oversize
        '{lcd_pkg::MODE_STRIP,  32'd0,          1'b0, TYPED,     32'd0,    1'b1},
        '{lcd_pkg::MODE_STRIP,  32'd5,          1'b0, TYPED, lcd_pkg::ALL_ONES, 1'b0},
        '{lcd_pkg::MODE_STRIP,  32'd999999998,  1'b0, PREDICTED, 32'd0,    1'b0},
        '{lcd_pkg::MODE_STRIP,  32'd999999999,  1'b0, PREDICTED, 32'd0,    1'b0},
        '{lcd_pkg::MODE_STRIP,  32'd1000000000, 1'b1, TYPED, lcd_pkg::ALL_ONES, 1'b0},
        '{lcd_pkg::MODE_STRIP,  32'hFFFF_FFFF,  1'b0, TYPED, lcd_pkg::ALL_ONES, 1'b0},
        '{lcd_pkg::MODE_STRIP,  32'd123456782,  1'b0, PREDICTED, 32'd0,    1'b0},
        // unused mode
        '{MODE_UNUSED,          32'd0,          1'b0, TYPED, lcd_pkg::ALL_ONES, 1'b0},
        '{MODE_UNUSED,          32'hFFFF_FFFF,  1'b1, TYPED, lcd_pkg::ALL_ONES, 1'b0}
    };

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    // slave side, driven on the falling edge
    logic        s_valid = 1'b0;
    logic [1:0]  s_mode  = 2'd0;
    logic [31:0] s_value = 32'd0;
    logic        s_last  = 1'b0;
    logic        s_axis_tready;

    // answer typed into the table for the transfer now on the bus
    logic         cur_typed = 1'b0;
    t_luhn_result cur_typed_res = '0;

    // master side
    logic        m_ready = 1'b0;
    logic        m_axis_tvalid;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // idling knobs, in percent
    int unsigned send_gap_pct  = 0;
    int unsigned recv_stall_pct = 0;

    t_luhn_result pending_results [$];
    int unsigned  mismatch_count = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    luhn_check_digit_unit #(
        .PAYLOAD_DIGITS (PAYLOAD_DIGITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_value),       // [31:0] value
        .s_axis_tuser  (s_mode),        // [1:0] mode
        .s_axis_tlast  (s_last),        // batch_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),  // [31:0] result_value
        .m_axis_tuser  (m_axis_tuser),  // [0] check_ok
        .m_axis_tlast  (m_axis_tlast)   // batch_last
    );

    // Luhn digit of the low PAYLOAD_DIGITS decimal digits: double every
    // second digit starting next to the check position, fold doubled
    // products above nine back to one digit, then take (sum * 9) mod 10.
    function automatic logic [3:0] luhn_digit_of(input logic [63:0] payload);
        logic [63:0] rest;
        int unsigned sum;
        int unsigned dg;
        int          pos;
        rest = payload;
        sum  = 0;
        for (pos = 0; pos < PAYLOAD_DIGITS; pos++) begin
            dg   = int'(rest % 64'd10);
            rest = rest / 64'd10;
            if (pos % 2 == 0) begin
                dg = dg * 2;
                if (dg > 9) begin
                    dg = dg - 9;
                end
            end
            sum += dg;
        end
        return 4'((sum * 9) % 10);
    endfunction

    // expected result of one transfer
    function automatic t_luhn_result predict_luhn(input logic [1:0]  mode,
                                                  input logic [31:0] value,
                                                  input logic        last);
        t_luhn_result res;
        logic [63:0]  wide;
        logic         match;
        res.value = lcd_pkg::ALL_ONES;
        res.ok    = 1'b0;
        res.last  = last;
        wide      = 64'(value);
        case (mode)
            lcd_pkg::MODE_ADD: begin
                // oversize payload or product past 32 bits is an error
                if (wide <= PAYLOAD_MAX) begin
                    wide = wide * 64'd10 + 64'(luhn_digit_of(wide));
                    if (wide <= 64'hFFFF_FFFF) begin
                        res.value = wide[31:0];
                        res.ok    = 1'b1;
                    end
                end
            end
            lcd_pkg::MODE_VERIFY, lcd_pkg::MODE_STRIP: begin
                match = (wide <= FULL_MAX) &&
                        (64'(luhn_digit_of(wide / 64'd10)) == wide % 64'd10);
                res.ok = match;
                if (mode == lcd_pkg::MODE_VERIFY) begin
                    res.value = 32'd0;
                end else if (match) begin
                    res.value = value / 32'd10;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Watch both sides on the rising edge: retire the oldest expectation for
    // each result transfer, then queue one for each accepted input transfer.
    always @(posedge i_clk) begin
        t_luhn_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %h", m_axis_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        flag_mismatch($sformatf("result_value %h, want %h",
                                                m_axis_tdata, want.value));
                    end
                    if (m_axis_tuser[0] !== want.ok) begin
                        flag_mismatch($sformatf("check_ok %b, want %b (value %h)",
                                                m_axis_tuser[0], want.ok, want.value));
                    end
                    if (m_axis_tlast !== want.last) begin
                        flag_mismatch($sformatf("batch_last %b, want %b",
                                                m_axis_tlast, want.last));
                    end
                end
            end
            if (s_valid && s_axis_tready) begin
                if (cur_typed) begin
                    pending_results.push_back(cur_typed_res);
                end else begin
                    pending_results.push_back(predict_luhn(s_mode, s_value, s_last));
                end
            end
        end
    end

    // Receiver: on each falling edge either hold tready high or drop it
    // for a burst of random length.
    initial begin
        int unsigned stall;
        forever begin
            @(negedge i_clk);
            if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
                stall   = $urandom_range(1, 18);
                m_ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Present one transfer. Call on a falling edge; return on the falling
    // edge after it is accepted, with tvalid still high.
    task automatic send_value(input logic [1:0]  mode,
                              input logic [31:0] value,
                              input logic        last,
                              input logic        typed,
                              input logic [31:0] exp_value,
                              input logic        exp_ok);
        int unsigned gap;
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            gap     = $urandom_range(1, 18);
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid             = 1'b1;
        s_mode              = mode;
        s_value             = value;
        s_last              = last;
        cur_typed           = typed;
        cur_typed_res.value = exp_value;
        cur_typed_res.ok    = exp_ok;
        cur_typed_res.last  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Pick one random transfer. Most are well-formed: payloads in range for
    // add, and values of up to nine digits with the right check digit for verify and
    // strip. The rest hit bad digits, the range limits, raw 32-bit noise
    // and the unused mode.
    task automatic send_random_value();
        int unsigned kind;
        logic [63:0] payload;
        logic [3:0]  dg;
        logic [1:0]  mode;
        logic [31:0] value;
        logic        last;
        kind = $urandom_range(99);
        last = ($urandom_range(3) == 0);
        mode = ($urandom_range(1) == 0) ? lcd_pkg::MODE_VERIFY : lcd_pkg::MODE_STRIP;
        if (kind < 30) begin
            mode  = lcd_pkg::MODE_ADD;
            value = ($urandom_range(3) == 0) ? $urandom_range(99)
                                             : $urandom_range(0, 99_999_999);
        end else if (kind < 80) begin
            payload = 64'($urandom_range(0, 99_999_999));
            dg      = luhn_digit_of(payload);
            // corrupt the check digit in some of them
            if (kind >= 65) begin
                dg = 4'((dg + $urandom_range(1, 9)) % 10);
            end
            value = 32'(payload * 64'd10 + 64'(dg));
        end else if (kind < 88) begin
            mode  = 2'($urandom_range(0, 2));
            value = $urandom();
        end else if (kind < 95) begin
            // hover around the payload and full-value limits
            mode  = 2'($urandom_range(0, 2));
            value = ($urandom_range(1) == 0) ? 32'd99_999_995 + $urandom_range(10)
                                             : 32'd999_999_995 + $urandom_range(10);
        end else begin
            mode  = MODE_UNUSED;
            value = $urandom();
        end
        send_value(mode, value, last, PREDICTED, 32'd0, 1'b0);
    endtask

    // stimulus
    initial begin
        int row;
        int seg;
        int item;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table under light idling
        send_gap_pct   = 15;
        recv_stall_pct = 5;
        for (row = 0; row < NUM_DIRECTED; row++) begin
            send_value(DIRECTED_ROWS[row].mode, DIRECTED_ROWS[row].value,
                       DIRECTED_ROWS[row].last, DIRECTED_ROWS[row].typed,
                       DIRECTED_ROWS[row].exp_value, DIRECTED_ROWS[row].exp_ok);
        end

        // hold off until the pipeline has drained completely
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);

        // random part in segments of different idling; the first and the last have none
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 10; recv_stall_pct = 4;  end
                2:       begin send_gap_pct = 30; recv_stall_pct = 12; end
                3:       begin send_gap_pct = 0;  recv_stall_pct = 20; end
                4:       begin send_gap_pct = 25; recv_stall_pct = 0;  end
                default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (item = 0; item < ITEMS_PER_SEG; item++) begin
                send_random_value();
            end
        end
        s_valid = 1'b0;

        // drain, then allow the pipeline latency for anything spurious
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            flag_mismatch("results still pending at end of run");
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
